// ===== hdl/cpcr_pkg.sv =====
// ---------------------------------------------------------------------------
// cpcr_pkg: shared types and constants for circle pair collision resolve
// Q16.8 widths, the request item carried from front to back, result record
// and the saturating add used on the output side.
// ---------------------------------------------------------------------------
package cpcr_pkg;

    localparam int POS_W     = 24;
    localparam int RAD_W     = 23;
    localparam int DIF_W     = POS_W + 1;
    localparam int D2_W      = 2 * DIF_W;
    localparam int RS_W      = RAD_W + 1;
    localparam int RSQ_W     = 2 * RS_W;
    localparam int DIST_W    = DIF_W;
    localparam int FRAC_W    = 8;

    // long division: quotient bits, denominator and numerator widths
    localparam int DIV_QB    = 34;
    localparam int DIV_DEN_W = D2_W;
    localparam int DIV_NUM_W = DIV_DEN_W + DIV_QB;
    localparam int DIV_LAT   = DIV_QB;

    // square root: one result bit per stage
    localparam int SQ_LAT    = DIST_W;
    localparam int SQ_REM_W  = DIST_W + 4;

    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = Q_PTR_W + 1;

    localparam int SUM_W     = DIV_QB + 2;
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(2 ** (POS_W - 1) - 1);
    localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-(2 ** (POS_W - 1)));

    typedef struct packed {
        logic signed [POS_W-1:0] x1;
        logic signed [POS_W-1:0] y1;
        logic        [RAD_W-1:0] r1;
        logic signed [POS_W-1:0] v1x;
        logic signed [POS_W-1:0] v1y;
        logic        [RAD_W-1:0] m1;
        logic signed [POS_W-1:0] x2;
        logic signed [POS_W-1:0] y2;
        logic        [RAD_W-1:0] r2;
        logic signed [POS_W-1:0] v2x;
        logic signed [POS_W-1:0] v2y;
        logic        [RAD_W-1:0] m2;
    } cpcr_in_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x1;
        logic signed [POS_W-1:0] y1;
        logic signed [POS_W-1:0] x2;
        logic signed [POS_W-1:0] y2;
        logic signed [POS_W-1:0] v1x;
        logic signed [POS_W-1:0] v1y;
        logic signed [POS_W-1:0] v2x;
        logic signed [POS_W-1:0] v2y;
        logic        [RAD_W-1:0] m1;
        logic        [RAD_W-1:0] m2;
        logic        [RS_W-1:0]  rs;
        logic signed [DIF_W-1:0] dx;
        logic signed [DIF_W-1:0] dy;
        logic        [D2_W-1:0]  d2;
        logic                    hit;
    } cpcr_item_t;

    typedef struct packed {
        logic                    hit;
        logic signed [POS_W-1:0] x1;
        logic signed [POS_W-1:0] y1;
        logic signed [POS_W-1:0] x2;
        logic signed [POS_W-1:0] y2;
        logic signed [POS_W-1:0] v1x;
        logic signed [POS_W-1:0] v1y;
        logic signed [POS_W-1:0] v2x;
        logic signed [POS_W-1:0] v2y;
    } cpcr_res_t;

    typedef struct packed {
        logic empty;
        logic full;
    } cpcr_qstat_t;

    function automatic logic [DIF_W-1:0] cpcr_mag(input logic signed [DIF_W-1:0] v);
        return v[DIF_W-1] ? -v : v;
    endfunction

    function automatic logic cpcr_pos(input logic signed [DIF_W-1:0] v);
        return !v[DIF_W-1] && (v != '0);
    endfunction

    // base plus or minus a magnitude, clamped to the signed 24-bit range
    function automatic logic signed [POS_W-1:0] cpcr_addsat(
        input logic signed [POS_W-1:0] base,
        input logic [DIV_QB-1:0] amt,
        input logic sub
    );
        logic signed [SUM_W-1:0] b;
        logic signed [SUM_W-1:0] a;
        logic signed [SUM_W-1:0] s;
        logic signed [POS_W-1:0] r;
        b = SUM_W'(base);
        a = $signed({2'b00, amt});
        s = sub ? b - a : b + a;
        if (s > SAT_MAX) begin
            r = SAT_MAX[POS_W-1:0];
        end else if (s < SAT_MIN) begin
            r = SAT_MIN[POS_W-1:0];
        end else begin
            r = s[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/cpcr_isqrt.sv =====
// ---------------------------------------------------------------------------
// cpcr_isqrt: pipelined integer square root
// Digit-by-digit root of the squared distance, one result bit per stage.
// ---------------------------------------------------------------------------
module cpcr_isqrt import cpcr_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  logic [D2_W-1:0]   rad,
    output logic [DIST_W-1:0] root
);

    logic [D2_W-1:0]     n_reg    [SQ_LAT];
    logic [SQ_REM_W-1:0] rem_reg  [SQ_LAT];
    logic [DIST_W-1:0]   root_reg [SQ_LAT];

    for (genvar k = 0; k < SQ_LAT; k++) begin : g_stage
        logic [D2_W-1:0]     n_in;
        logic [SQ_REM_W-1:0] rem_in;
        logic [DIST_W-1:0]   root_in;
        logic [SQ_REM_W-1:0] rem_sh;
        logic [SQ_REM_W-1:0] trial;
        logic                ge;

        if (k == 0) begin : g_first
            assign n_in    = rad;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_rest
            assign n_in    = n_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        assign rem_sh = {rem_in[SQ_REM_W-3:0], n_in[D2_W-1 -: 2]};
        assign trial  = {2'b00, root_in, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[k]    <= {n_in[D2_W-3:0], 2'b00};
                rem_reg[k]  <= ge ? rem_sh - trial : rem_sh;
                root_reg[k] <= {root_in[DIST_W-2:0], ge};
            end
        end
    end

    assign root = root_reg[SQ_LAT-1];

endmodule

// ===== hdl/cpcr_div.sv =====
// ---------------------------------------------------------------------------
// cpcr_div: pipelined unsigned long division
// Restoring division, one quotient bit per stage; the quotient must fit
// DIV_QB bits, so the top part of the numerator starts as the remainder.
// ---------------------------------------------------------------------------
module cpcr_div import cpcr_pkg::*; (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic [DIV_QB-1:0]    quo
);

    logic [DIV_DEN_W-1:0] rem_reg [DIV_LAT];
    logic [DIV_DEN_W-1:0] den_reg [DIV_LAT];
    logic [DIV_QB-1:0]    lo_reg  [DIV_LAT];

    for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
        logic [DIV_DEN_W-1:0] rem_in;
        logic [DIV_DEN_W-1:0] den_in;
        logic [DIV_QB-1:0]    lo_in;
        logic [DIV_DEN_W:0]   sh;
        logic [DIV_DEN_W:0]   diff;
        logic                 ge;

        if (k == 0) begin : g_first
            assign rem_in = num[DIV_NUM_W-1 -: DIV_DEN_W];
            assign den_in = den;
            assign lo_in  = num[DIV_QB-1:0];
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign lo_in  = lo_reg[k-1];
        end

        // numerator bits leave the top of lo while quotient bits enter below
        assign sh   = {rem_in, lo_in[DIV_QB-1]};
        assign diff = sh - {1'b0, den_in};
        assign ge   = sh >= {1'b0, den_in};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? diff[DIV_DEN_W-1:0] : sh[DIV_DEN_W-1:0];
                den_reg[k] <= den_in;
                lo_reg[k]  <= {lo_in[DIV_QB-2:0], ge};
            end
        end
    end

    assign quo = lo_reg[DIV_LAT-1];

endmodule

// ===== hdl/cpcr_front.sv =====
// ---------------------------------------------------------------------------
// cpcr_front: request intake and overlap test
// Registers the pair with differences and squares, forms the squared
// distance and hit flag, and parks the item in a short queue.
// ---------------------------------------------------------------------------
module cpcr_front import cpcr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  cpcr_in_t    s_pair,
    input  logic        q_pop,
    output cpcr_item_t  q_item,
    output cpcr_qstat_t q_stat
);

    logic                    fr_vld_reg, fr_vld_next;
    cpcr_item_t              fr_item_reg, fr_item_next;
    logic [D2_W-1:0]         sqx_reg, sqx_next;
    logic [D2_W-1:0]         sqy_reg, sqy_next;
    logic [RSQ_W-1:0]        rsq_reg, rsq_next;
    logic signed [DIF_W-1:0] dx, dy;
    logic [DIF_W-1:0]        mdx, mdy;
    logic [RS_W-1:0]         rs;
    logic                    take, push;
    cpcr_item_t              push_item;

    cpcr_item_t              q_mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0]      cnt_reg;

    always_comb begin
        dx  = DIF_W'(s_pair.x1) - DIF_W'(s_pair.x2);
        dy  = DIF_W'(s_pair.y1) - DIF_W'(s_pair.y2);
        mdx = cpcr_mag(dx);
        mdy = cpcr_mag(dy);
        rs  = RS_W'(s_pair.r1) + RS_W'(s_pair.r2);

        fr_item_next     = '0;
        fr_item_next.x1  = s_pair.x1;
        fr_item_next.y1  = s_pair.y1;
        fr_item_next.x2  = s_pair.x2;
        fr_item_next.y2  = s_pair.y2;
        fr_item_next.v1x = s_pair.v1x;
        fr_item_next.v1y = s_pair.v1y;
        fr_item_next.v2x = s_pair.v2x;
        fr_item_next.v2y = s_pair.v2y;
        fr_item_next.m1  = s_pair.m1;
        fr_item_next.m2  = s_pair.m2;
        fr_item_next.rs  = rs;
        fr_item_next.dx  = dx;
        fr_item_next.dy  = dy;

        sqx_next = D2_W'(mdx) * D2_W'(mdx);
        sqy_next = D2_W'(mdy) * D2_W'(mdy);
        rsq_next = RSQ_W'(rs) * RSQ_W'(rs);
    end

    assign q_stat.full  = cnt_reg == Q_CNT_W'(Q_DEPTH);
    assign q_stat.empty = cnt_reg == '0;
    assign q_item       = q_mem_reg[rd_ptr_reg];

    assign push    = fr_vld_reg && !q_stat.full;
    assign s_ready = !fr_vld_reg || !q_stat.full;
    assign take    = s_valid && s_ready;

    assign fr_vld_next = take ? 1'b1 : (push ? 1'b0 : fr_vld_reg);

    // zero distance counts as no collision
    always_comb begin
        push_item     = fr_item_reg;
        push_item.d2  = sqx_reg + sqy_reg;
        push_item.hit = (push_item.d2 != '0) && (push_item.d2 <= D2_W'(rsq_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fr_vld_reg <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            fr_vld_reg <= fr_vld_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            cnt_reg <= cnt_reg + Q_CNT_W'(push) - Q_CNT_W'(q_pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            fr_item_reg <= fr_item_next;
            sqx_reg     <= sqx_next;
            sqy_reg     <= sqy_next;
            rsq_reg     <= rsq_next;
        end
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/cpcr_back.sv =====
// ---------------------------------------------------------------------------
// cpcr_back: collision resolve pipeline
// Square root, push-apart and elastic exchange along the normal, with all
// stages advancing together and the last stage as output register.
// ---------------------------------------------------------------------------
module cpcr_back import cpcr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cpcr_item_t  q_item,
    input  cpcr_qstat_t q_stat,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output cpcr_res_t   m_res
);

    // stage numbers, counted from the register loaded out of the queue
    localparam int T_PW  = 1;
    localparam int T_W   = 2;
    localparam int T_PP  = 3;
    localparam int T_NA  = 4;
    localparam int T_AX  = T_NA + DIV_LAT;
    localparam int T_PM  = T_AX + 1;
    localparam int T_ND  = T_AX + 2;
    localparam int T_FIN = T_ND + DIV_LAT;
    localparam int T_OUT = T_FIN + 1;
    localparam int T_SQ  = SQ_LAT;

    localparam int PW_W = 2 * DIF_W;
    localparam int W_W  = PW_W + 1;
    localparam int HW   = DIF_W;
    localparam int QH   = DIV_QB / 2;
    localparam int PP_W = DIF_W + RS_W;
    localparam int DP_W = (DIV_QB - QH) + RS_W;

    logic                    adv;
    logic [T_OUT:0]          vld_reg;
    cpcr_item_t              item_reg [T_FIN+1];

    logic signed [DIF_W-1:0] dvx, dvy, ux, uy;
    logic signed [PW_W-1:0]  pwx_reg, pwy_reg;
    logic signed [W_W-1:0]   w_sum;
    logic [PW_W-1:0]         wmag_reg;
    logic                    wneg_reg;
    logic [DIF_W-1:0]        umx, umy;
    logic [PW_W-1:0]         ppxl_reg, ppxh_reg, ppyl_reg, ppyh_reg;
    logic                    sx3_reg, sy3_reg;
    logic [DIV_NUM_W-1:0]    numx_reg, numy_reg;
    logic                    sx_reg [T_NA:T_FIN];
    logic                    sy_reg [T_NA:T_FIN];
    logic [DIV_QB-1:0]       qax, qay;

    logic [DIST_W-1:0]       dist_sq;
    logic [DIST_W-1:0]       dist_reg [T_SQ+1:T_AX];
    logic [DIST_W-1:0]       push_full;
    logic [RS_W-1:0]         push_amt;
    logic [RS_W-1:0]         m1x2, m2x2;
    logic [PP_W-1:0]         posx_reg, posy_reg;
    logic [DIST_W-1:0]       dpm_reg, dnd_reg;
    logic [DP_W-1:0]         p1xl_reg, p1xh_reg, p1yl_reg, p1yh_reg;
    logic [DP_W-1:0]         p2xl_reg, p2xh_reg, p2yl_reg, p2yh_reg;

    logic [DIV_NUM_W-1:0]    npx_reg, npy_reg, n1x_reg, n1y_reg, n2x_reg, n2y_reg;
    logic [RS_W-1:0]         msum;
    logic [DIV_DEN_W-1:0]    den_pos, den_m;
    logic [DIV_QB-1:0]       qpx, qpy, q1x, q1y, q2x, q2y;

    cpcr_item_t              fin;
    cpcr_res_t               res_reg, res_next;

    assign adv     = !vld_reg[T_OUT] || m_ready;
    assign q_pop   = adv && !q_stat.empty;
    assign m_valid = vld_reg[T_OUT];
    assign m_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[T_OUT-1:0], q_pop};
        end
    end

    // relative velocity projected on the normal u = -(p1 - p2)
    assign dvx   = DIF_W'(item_reg[0].v1x) - DIF_W'(item_reg[0].v2x);
    assign dvy   = DIF_W'(item_reg[0].v1y) - DIF_W'(item_reg[0].v2y);
    assign ux    = -item_reg[0].dx;
    assign uy    = -item_reg[0].dy;
    assign w_sum = W_W'(pwx_reg) + W_W'(pwy_reg);
    assign umx   = cpcr_mag(item_reg[T_W].dx);
    assign umy   = cpcr_mag(item_reg[T_W].dy);

    cpcr_isqrt u_sqrt (
        .aclk (aclk),
        .en   (adv),
        .rad  (item_reg[0].d2),
        .root (dist_sq)
    );

    cpcr_div u_div_ax (.aclk(aclk), .en(adv), .num(numx_reg),
                       .den(item_reg[T_NA].d2), .quo(qax));
    cpcr_div u_div_ay (.aclk(aclk), .en(adv), .num(numy_reg),
                       .den(item_reg[T_NA].d2), .quo(qay));

    assign push_full = DIST_W'(item_reg[T_AX].rs) - dist_reg[T_AX];
    assign push_amt  = push_full[RS_W-1:0];
    assign m1x2      = {item_reg[T_AX].m1, 1'b0};
    assign m2x2      = {item_reg[T_AX].m2, 1'b0};

    assign msum    = RS_W'(item_reg[T_ND].m1) + RS_W'(item_reg[T_ND].m2);
    assign den_m   = DIV_DEN_W'(msum) << FRAC_W;
    assign den_pos = DIV_DEN_W'({dnd_reg, 1'b0});

    cpcr_div u_div_px (.aclk(aclk), .en(adv), .num(npx_reg), .den(den_pos), .quo(qpx));
    cpcr_div u_div_py (.aclk(aclk), .en(adv), .num(npy_reg), .den(den_pos), .quo(qpy));
    cpcr_div u_div_1x (.aclk(aclk), .en(adv), .num(n1x_reg), .den(den_m), .quo(q1x));
    cpcr_div u_div_1y (.aclk(aclk), .en(adv), .num(n1y_reg), .den(den_m), .quo(q1y));
    cpcr_div u_div_2x (.aclk(aclk), .en(adv), .num(n2x_reg), .den(den_m), .quo(q2x));
    cpcr_div u_div_2y (.aclk(aclk), .en(adv), .num(n2y_reg), .den(den_m), .quo(q2y));

    // signs: push follows dx, velocity change follows the sign of a
    assign fin = item_reg[T_FIN];
    always_comb begin
        res_next     = '0;
        res_next.hit = fin.hit;
        res_next.x1  = fin.x1;
        res_next.y1  = fin.y1;
        res_next.x2  = fin.x2;
        res_next.y2  = fin.y2;
        res_next.v1x = fin.v1x;
        res_next.v1y = fin.v1y;
        res_next.v2x = fin.v2x;
        res_next.v2y = fin.v2y;
        if (fin.hit) begin
            res_next.x1 = cpcr_addsat(fin.x1, qpx, fin.dx[DIF_W-1]);
            res_next.y1 = cpcr_addsat(fin.y1, qpy, fin.dy[DIF_W-1]);
            res_next.x2 = cpcr_addsat(fin.x2, qpx, !fin.dx[DIF_W-1]);
            res_next.y2 = cpcr_addsat(fin.y2, qpy, !fin.dy[DIF_W-1]);
            // both masses zero leaves the velocities alone
            if ((fin.m1 != '0) || (fin.m2 != '0)) begin
                res_next.v1x = cpcr_addsat(fin.v1x, q1x, !sx_reg[T_FIN]);
                res_next.v1y = cpcr_addsat(fin.v1y, q1y, !sy_reg[T_FIN]);
                res_next.v2x = cpcr_addsat(fin.v2x, q2x, sx_reg[T_FIN]);
                res_next.v2y = cpcr_addsat(fin.v2y, q2y, sy_reg[T_FIN]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            item_reg[0] <= q_item;
            for (int t = 1; t <= T_FIN; t++) begin
                item_reg[t] <= item_reg[t-1];
            end

            pwx_reg <= PW_W'(dvx) * PW_W'(ux);
            pwy_reg <= PW_W'(dvy) * PW_W'(uy);

            wneg_reg <= w_sum[W_W-1];
            wmag_reg <= w_sum[W_W-1] ? PW_W'(-w_sum) : PW_W'(w_sum);

            ppxl_reg <= PW_W'(wmag_reg[HW-1:0]) * PW_W'(umx);
            ppxh_reg <= PW_W'(wmag_reg[PW_W-1:HW]) * PW_W'(umx);
            ppyl_reg <= PW_W'(wmag_reg[HW-1:0]) * PW_W'(umy);
            ppyh_reg <= PW_W'(wmag_reg[PW_W-1:HW]) * PW_W'(umy);
            sx3_reg  <= wneg_reg ^ cpcr_pos(item_reg[T_W].dx);
            sy3_reg  <= wneg_reg ^ cpcr_pos(item_reg[T_W].dy);

            numx_reg <= ((DIV_NUM_W'(ppxh_reg) << HW) + DIV_NUM_W'(ppxl_reg)) << FRAC_W;
            numy_reg <= ((DIV_NUM_W'(ppyh_reg) << HW) + DIV_NUM_W'(ppyl_reg)) << FRAC_W;
            sx_reg[T_NA] <= sx3_reg;
            sy_reg[T_NA] <= sy3_reg;
            for (int t = T_NA + 1; t <= T_FIN; t++) begin
                sx_reg[t] <= sx_reg[t-1];
                sy_reg[t] <= sy_reg[t-1];
            end

            dist_reg[T_SQ+1] <= dist_sq;
            for (int t = T_SQ + 2; t <= T_AX; t++) begin
                dist_reg[t] <= dist_reg[t-1];
            end

            posx_reg <= PP_W'(cpcr_mag(item_reg[T_AX].dx)) * PP_W'(push_amt);
            posy_reg <= PP_W'(cpcr_mag(item_reg[T_AX].dy)) * PP_W'(push_amt);
            dpm_reg  <= dist_reg[T_AX];
            p1xl_reg <= DP_W'(qax[QH-1:0]) * DP_W'(m2x2);
            p1xh_reg <= DP_W'(qax[DIV_QB-1:QH]) * DP_W'(m2x2);
            p1yl_reg <= DP_W'(qay[QH-1:0]) * DP_W'(m2x2);
            p1yh_reg <= DP_W'(qay[DIV_QB-1:QH]) * DP_W'(m2x2);
            p2xl_reg <= DP_W'(qax[QH-1:0]) * DP_W'(m1x2);
            p2xh_reg <= DP_W'(qax[DIV_QB-1:QH]) * DP_W'(m1x2);
            p2yl_reg <= DP_W'(qay[QH-1:0]) * DP_W'(m1x2);
            p2yh_reg <= DP_W'(qay[DIV_QB-1:QH]) * DP_W'(m1x2);

            npx_reg <= DIV_NUM_W'(posx_reg);
            npy_reg <= DIV_NUM_W'(posy_reg);
            dnd_reg <= dpm_reg;
            n1x_reg <= (DIV_NUM_W'(p1xh_reg) << QH) + DIV_NUM_W'(p1xl_reg);
            n1y_reg <= (DIV_NUM_W'(p1yh_reg) << QH) + DIV_NUM_W'(p1yl_reg);
            n2x_reg <= (DIV_NUM_W'(p2xh_reg) << QH) + DIV_NUM_W'(p2xl_reg);
            n2y_reg <= (DIV_NUM_W'(p2yh_reg) << QH) + DIV_NUM_W'(p2yl_reg);

            res_reg <= res_next;
        end
    end

endmodule

// ===== hdl/circle_pair_collision_resolve.sv =====
// ---------------------------------------------------------------------------
// circle_pair_collision_resolve: overlap test and elastic response for two
// circles in signed Q16.8, one pair request in, one resolved pair out.
// ---------------------------------------------------------------------------
//  channel   direction  handshake            carries
//  s_        in         s_valid / s_ready    two circles: centre, radius, velocity, mass
//  m_        out        m_valid / m_ready    hit flag, new centres, new velocities
//
//  one request per cycle sustained while nothing stalls; the result path runs
//  through the 25-stage square root feeding the push divider, in parallel
//  with two chained 34-stage dividers on the velocity side.
//  aresetn (synchronous) empties the front register, queue and pipeline.
//  a held result stops the back pipeline; the four-entry queue and the front
//  register keep taking requests until they fill.
// ---------------------------------------------------------------------------
module circle_pair_collision_resolve import cpcr_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [POS_W-1:0] s_first_x,
    input  logic signed [POS_W-1:0] s_first_y,
    input  logic        [RAD_W-1:0] s_first_radius,
    input  logic signed [POS_W-1:0] s_first_vel_x,
    input  logic signed [POS_W-1:0] s_first_vel_y,
    input  logic        [RAD_W-1:0] s_first_mass,
    input  logic signed [POS_W-1:0] s_second_x,
    input  logic signed [POS_W-1:0] s_second_y,
    input  logic        [RAD_W-1:0] s_second_radius,
    input  logic signed [POS_W-1:0] s_second_vel_x,
    input  logic signed [POS_W-1:0] s_second_vel_y,
    input  logic        [RAD_W-1:0] s_second_mass,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_hit,
    output logic signed [POS_W-1:0] m_new_first_x,
    output logic signed [POS_W-1:0] m_new_first_y,
    output logic signed [POS_W-1:0] m_new_second_x,
    output logic signed [POS_W-1:0] m_new_second_y,
    output logic signed [POS_W-1:0] m_new_first_vel_x,
    output logic signed [POS_W-1:0] m_new_first_vel_y,
    output logic signed [POS_W-1:0] m_new_second_vel_x,
    output logic signed [POS_W-1:0] m_new_second_vel_y
);

    cpcr_in_t    s_pair;
    cpcr_item_t  q_item;
    cpcr_qstat_t q_stat;
    logic        q_pop;
    cpcr_res_t   m_res;

    assign s_pair.x1  = s_first_x;
    assign s_pair.y1  = s_first_y;
    assign s_pair.r1  = s_first_radius;
    assign s_pair.v1x = s_first_vel_x;
    assign s_pair.v1y = s_first_vel_y;
    assign s_pair.m1  = s_first_mass;
    assign s_pair.x2  = s_second_x;
    assign s_pair.y2  = s_second_y;
    assign s_pair.r2  = s_second_radius;
    assign s_pair.v2x = s_second_vel_x;
    assign s_pair.v2y = s_second_vel_y;
    assign s_pair.m2  = s_second_mass;

    cpcr_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_pair  (s_pair),
        .q_pop   (q_pop),
        .q_item  (q_item),
        .q_stat  (q_stat)
    );

    cpcr_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_item  (q_item),
        .q_stat  (q_stat),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    assign m_hit              = m_res.hit;
    assign m_new_first_x      = m_res.x1;
    assign m_new_first_y      = m_res.y1;
    assign m_new_second_x     = m_res.x2;
    assign m_new_second_y     = m_res.y2;
    assign m_new_first_vel_x  = m_res.v1x;
    assign m_new_first_vel_y  = m_res.v1y;
    assign m_new_second_vel_x = m_res.v2x;
    assign m_new_second_vel_y = m_res.v2y;

`ifndef NO_ASSERTIONS
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> q_stat.full)
        else $error("intake stalled while queue has room");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("queue popped while empty");

    a_queue_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("queue both full and empty");
`endif

endmodule

// ===== verif/circle_pair_collision_resolve_tb.sv =====
// ---------------------------------------------------------------------------
// circle_pair_collision_resolve_tb: self-checking bench for the pair resolver
// Streams circle pairs into the block with random gaps and output stalls,
// predicts each resolved pair in fixed point and compares every result in
// order of arrival.
// ---------------------------------------------------------------------------
module circle_pair_collision_resolve_tb;
    import cpcr_pkg::*;

    localparam int N_RANDOM    = 1850;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_WAIT  = 300;

    class collision_scoreboard;
        cpcr_res_t pending[$];
        int        errors;

        function automatic longint unsigned mag64(input longint v);
            return v < 0 ? longint'(0) - v : v;
        endfunction

        function automatic longint unsigned int_sqrt(input longint unsigned n);
            longint unsigned root;
            longint unsigned bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (n >= root + bitv) begin
                    n    = n - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            return root;
        endfunction

        // trunc(a*b/d) with a wide product, sign from a and neg_b
        function automatic longint scaled_div(input longint a, input longint unsigned b,
                                              input longint unsigned d, input bit neg_b);
            logic [127:0] prod;
            logic [127:0] quo;
            longint       q;
            prod = 128'(mag64(a)) * 128'(b);
            quo  = prod / 128'(d);
            q    = longint'(quo[63:0]);
            return ((a < 0) != neg_b) ? -q : q;
        endfunction

        function automatic logic signed [POS_W-1:0] clamp24(input longint v);
            if (v > 64'sd8388607) return 24'sh7fffff;
            if (v < -64'sd8388608) return 24'sh800000;
            return v[POS_W-1:0];
        endfunction

        function automatic cpcr_res_t resolve_pair(input cpcr_in_t p);
            cpcr_res_t       r;
            longint          x1, y1, x2, y2, v1x, v1y, v2x, v2y, dx, dy;
            longint          px, py, w, ax, ay;
            longint          nx1, ny1, nx2, ny2, nv1x, nv1y, nv2x, nv2y;
            longint unsigned m1, m2, rs, d2, root_d, push, den;
            bit              hit;
            x1 = longint'(p.x1);  y1 = longint'(p.y1);
            v1x = longint'(p.v1x);  v1y = longint'(p.v1y);
            x2 = longint'(p.x2);  y2 = longint'(p.y2);
            v2x = longint'(p.v2x);  v2y = longint'(p.v2y);
            m1 = 64'(p.m1);  m2 = 64'(p.m2);
            rs = longint'(p.r1) + longint'(p.r2);
            dx = x1 - x2;
            dy = y1 - y2;
            d2 = mag64(dx) * mag64(dx) + mag64(dy) * mag64(dy);
            hit = (d2 != 0) && (d2 <= rs * rs);
            nx1 = x1;  ny1 = y1;  nx2 = x2;  ny2 = y2;
            nv1x = v1x;  nv1y = v1y;  nv2x = v2x;  nv2y = v2y;
            if (hit) begin
                root_d = int_sqrt(d2);
                push = rs - root_d;
                px = scaled_div(dx, push, 2 * root_d, 1'b0);
                py = scaled_div(dy, push, 2 * root_d, 1'b0);
                nx1 = x1 + px;  ny1 = y1 + py;
                nx2 = x2 - px;  ny2 = y2 - py;
                if (m1 + m2 != 0) begin
                    // normal points from first to second
                    w   = (v1x - v2x) * (-dx) + (v1y - v2y) * (-dy);
                    ax  = scaled_div(w, mag64(dx) << 8, d2, dx > 0);
                    ay  = scaled_div(w, mag64(dy) << 8, d2, dy > 0);
                    den = (m1 + m2) << 8;
                    nv1x = v1x - scaled_div(ax, 2 * m2, den, 1'b0);
                    nv1y = v1y - scaled_div(ay, 2 * m2, den, 1'b0);
                    nv2x = v2x + scaled_div(ax, 2 * m1, den, 1'b0);
                    nv2y = v2y + scaled_div(ay, 2 * m1, den, 1'b0);
                end
            end
            r.hit = hit;
            r.x1  = clamp24(nx1);   r.y1  = clamp24(ny1);
            r.x2  = clamp24(nx2);   r.y2  = clamp24(ny2);
            r.v1x = clamp24(nv1x);  r.v1y = clamp24(nv1y);
            r.v2x = clamp24(nv2x);  r.v2y = clamp24(nv2y);
            return r;
        endfunction

        function void note_request(input cpcr_in_t p);
            pending = {pending, resolve_pair(p)};
        endfunction

        function void check_result(input cpcr_res_t got);
            cpcr_res_t want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            if (got.hit !== want.hit || got.x1 !== want.x1 || got.y1 !== want.y1 ||
                got.x2 !== want.x2 || got.y2 !== want.y2 || got.v1x !== want.v1x ||
                got.v1y !== want.v1y || got.v2x !== want.v2x || got.v2y !== want.v2y) begin
                errors++;
                if (errors <= 10) $display("mismatch\n  exp %p\n  got %p", want, got);
            end
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    cpcr_in_t                req;
    logic                    m_valid;
    logic                    m_ready;
    cpcr_res_t               res;
    collision_scoreboard     sb;
    int                      cycles;
    bit                      stim_done;

    circle_pair_collision_resolve DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_first_x          (req.x1),
        .s_first_y          (req.y1),
        .s_first_radius     (req.r1),
        .s_first_vel_x      (req.v1x),
        .s_first_vel_y      (req.v1y),
        .s_first_mass       (req.m1),
        .s_second_x         (req.x2),
        .s_second_y         (req.y2),
        .s_second_radius    (req.r2),
        .s_second_vel_x     (req.v2x),
        .s_second_vel_y     (req.v2y),
        .s_second_mass      (req.m2),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_hit              (res.hit),
        .m_new_first_x      (res.x1),
        .m_new_first_y      (res.y1),
        .m_new_second_x     (res.x2),
        .m_new_second_y     (res.y2),
        .m_new_first_vel_x  (res.v1x),
        .m_new_first_vel_y  (res.v1y),
        .m_new_second_vel_x (res.v2x),
        .m_new_second_vel_y (res.v2y)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    function automatic int gap_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45) return 0;
        if (sel < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [RAD_W-1:0] rand_mass();
        case ($urandom_range(0, 3))
            0: return RAD_W'($urandom_range(1, 8388607));
            1: return RAD_W'($urandom_range(1, 4096));
            2: return 23'd1;
            default: return RAD_W'($urandom_range(128, 1024));
        endcase
    endfunction

    function automatic logic signed [POS_W-1:0] rand_vel();
        if ($urandom_range(0, 3) == 0) return POS_W'($urandom());
        return $signed(24'($urandom_range(0, 8000))) - 24'sd4000;
    endfunction

    // mostly overlapping pairs with random content, the rest full-range noise
    function automatic cpcr_in_t rand_pair();
        cpcr_in_t     p;
        logic [287:0] raw;
        int           span, ddx, ddy, reach;
        raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
               $urandom(), $urandom(), $urandom()};
        p = raw[$bits(cpcr_in_t)-1:0];
        if ($urandom_range(0, 9) < 2) begin
            if (p.m1 == 0) p.m1 = 23'd1;
            if (p.m2 == 0) p.m2 = 23'd1;
            return p;
        end
        span  = ($urandom_range(0, 7) == 0) ? 2000000 : 3000;
        ddx   = $urandom_range(0, 2 * span) - span;
        ddy   = $urandom_range(0, 2 * span) - span;
        reach = (ddx < 0 ? -ddx : ddx) + (ddy < 0 ? -ddy : ddy);
        // edge cases near the limits exercise position saturation
        if ($urandom_range(0, 9) == 0) p.x1 = $urandom_range(0, 1) ? 24'sh7ffff0 : 24'sh800010;
        p.x2 = POS_W'(p.x1 - ddx);
        p.y2 = POS_W'(p.y1 - ddy);
        p.r1 = RAD_W'($urandom_range(0, reach + 500));
        p.r2 = (reach + 1 > p.r1) ?
               RAD_W'($urandom_range(reach - p.r1, reach + 800 - p.r1)) : '0;
        if ($urandom_range(0, 7) == 0) p.r2 = RAD_W'($urandom_range(0, 3000));
        p.v1x = rand_vel();  p.v1y = rand_vel();
        p.v2x = rand_vel();  p.v2y = rand_vel();
        p.m1  = rand_mass(); p.m2  = rand_mass();
        return p;
    endfunction

    task automatic send_pair(input cpcr_in_t p);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        req     = p;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(p);
        @(negedge aclk);
    endtask

    task automatic send_directed();
        cpcr_in_t p;
        p = '0;
        p.m1 = 23'd256;  p.m2 = 23'd256;
        send_pair(p);                                   // coincident centres
        p.x1 = 24'sd1000;  p.r1 = 23'd200;  p.r2 = 23'd200;
        send_pair(p);                                   // apart, pass through
        p.x1 = 24'sd300;  p.v1x = -24'sd512;  p.v2x = 24'sd256;
        send_pair(p);                                   // head-on overlap in x
        p.x1 = '0;  p.y1 = 24'sd100;  p.v1y = 24'sd77;  p.m2 = 23'h7fffff;
        send_pair(p);                                   // overlap in y, heavy partner
        p.x1 = 24'sd400;  p.r1 = 23'd200;  p.r2 = 23'd200;
        send_pair(p);                                   // slightly beyond touching, no hit
        p.x1 = 24'sd1;  p.y1 = '0;  p.m1 = 23'd1;  p.m2 = 23'd1;
        send_pair(p);                                   // one lsb apart
        p = '1;
        p.x1 = 24'sh7fffff;  p.y1 = 24'sh7fffff;  p.x2 = 24'sh7fff00;  p.y2 = 24'sh7fff00;
        p.v1x = 24'sh7fffff; p.v1y = 24'sh7fffff; p.v2x = 24'sh800000; p.v2y = 24'sh800000;
        send_pair(p);                                   // saturate positions and velocities
        p.x1 = 24'sh800000;  p.y1 = 24'sh800000;  p.x2 = 24'sh800100;  p.y2 = 24'sh800100;
        p.v1x = 24'sh800000; p.v1y = 24'sh800000; p.v2x = 24'sh7fffff; p.v2y = 24'sh7fffff;
        send_pair(p);
        p.x1 = 24'sh7fffff;  p.x2 = 24'sh800000;  p.y1 = 24'sh7fffff;  p.y2 = 24'sh800000;
        send_pair(p);                                   // widest separation, max radii
        p.r1 = '0;  p.r2 = '0;
        send_pair(p);
        p = '0;
        p.x1 = 24'sd50;  p.y1 = -24'sd30;  p.r1 = 23'h7fffff;  p.r2 = 23'h7fffff;
        p.v1x = 24'sd1;  p.m1 = 23'h7fffff;  p.m2 = 23'h7fffff;
        send_pair(p);
    endtask

    initial begin
        sb        = new();
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        req       = '0;
        stim_done = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        send_directed();
        for (int i = 0; i < N_RANDOM; i++) send_pair(rand_pair());
        s_valid = 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        stim_done = 1'b1;
    end

    // output stalls: runs of ready and not ready, some of them long
    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            m_ready = 1'b1;
            repeat ($urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(20, 200))
                @(negedge aclk);
            m_ready = 1'b0;
            repeat (gap_len()) @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(res);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
